### src/assert_macros.svh
// Assertion macros used by the checker file of the ready queue
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, suspended while reset is asserted
`define RRQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Concurrent check on the rising clock edge that also runs during reset
`define RRQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### src/rrq_pkg.sv
// Package of types, codes and field positions for the round-robin ready queue
`timescale 1ns / 1ps
`default_nettype none

package rrq_pkg;

    // Default sizes handed to the top level parameters
    localparam int NUM_THREADS_DEF = 64;
    localparam int NUM_CORES_DEF   = 4;

    // Field widths of the item and result
    localparam int FUNC_W       = 3;
    localparam int CORE_FIELD_W = 2;
    localparam int TID_W        = 6;
    localparam int TIME_W       = 64;
    localparam int MASK_W       = 4;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 80;

    // Input item layout, lowest bit first
    localparam int IN_FUNC_LSB = 0;
    localparam int IN_CORE_LSB = 3;
    localparam int IN_TID_LSB  = 5;
    localparam int IN_NOW_LSB  = 11;

    // Result item layout, lowest bit first
    localparam int OUT_ACC_LSB   = 0;
    localparam int OUT_SEL_T_LSB = 1;
    localparam int OUT_SEL_V_LSB = 7;
    localparam int OUT_OUT_T_LSB = 8;
    localparam int OUT_OUT_V_LSB = 14;
    localparam int OUT_TIME_LSB  = 15;
    localparam int OUT_EMPTY_LSB = 79;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_ENQUEUE  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_SCHEDULE = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_SWITCH   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_VACATE   = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_CHARGE_WR,
        ST_POP_RD,
        ST_POP_WR,
        ST_UNLINK_WR,
        ST_VACATE,
        ST_FINISH
    } rrq_state_t;

    // Strobes from the controller to the datapath
    typedef struct packed {
        logic latch;          // capture the input item, clear the result
        logic set_acc;        // mark the item as taking effect
        logic enqueue;        // push the item's thread at the tail
        logic unlink_rd_tid;  // read the links of the item's thread
        logic unlink_rd_head; // read the links of the queue head
        logic unlink_wr;      // unlink the thread whose links were read
        logic time_rd;        // read the current thread's run time, form the delta
        logic charge_wr;      // charge and requeue the current thread
        logic set_start;      // restart the core's time slice at now
        logic load_switch;    // make the item's thread current
        logic pop_to_core;    // make the unlinked head current
        logic clear_core;     // leave the core without a thread
        logic vacate_wr;      // report and clear the core's thread
        logic load_out;       // move the result into the output register
    } rrq_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              tid_ok;
        logic              tid_queued;
        logic              core_ok;
        logic              core_en;
        logic              cur_valid;
        logic              q_valid;
        logic              out_free;
    } rrq_status_t;

endpackage

`default_nettype wire

### src/rrq_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
`default_nettype none

module rrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### src/rrq_ctrl.sv
// Controller state machine that sequences each queue operation
`timescale 1ns / 1ps
`default_nettype none

module rrq_ctrl
    import rrq_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire rrq_status_t sts,
    output rrq_cmd_t         cmd
);

    rrq_state_t state_reg;
    rrq_state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Take items only between operations
    assign s_tready = (state_reg == ST_IDLE);

    // Next state and command strobes
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch  = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                state_next = ST_FINISH;
                unique case (sts.func)
                    FUNC_ENQUEUE: begin
                        if (sts.tid_ok && !sts.tid_queued) begin
                            cmd.set_acc = 1'b1;
                            cmd.enqueue = 1'b1;
                        end
                    end
                    FUNC_REMOVE: begin
                        if (sts.tid_ok && sts.tid_queued) begin
                            cmd.set_acc       = 1'b1;
                            cmd.unlink_rd_tid = 1'b1;
                            state_next        = ST_UNLINK_WR;
                        end
                    end
                    FUNC_SCHEDULE: begin
                        if (sts.core_ok && sts.core_en) begin
                            cmd.set_acc = 1'b1;
                            if (sts.cur_valid) begin
                                cmd.time_rd = 1'b1;
                                state_next  = ST_CHARGE_WR;
                            end else begin
                                cmd.set_start = 1'b1;
                                state_next    = ST_POP_RD;
                            end
                        end
                    end
                    FUNC_SWITCH: begin
                        if (sts.core_ok && sts.tid_ok) begin
                            cmd.set_acc = 1'b1;
                            if (sts.cur_valid) begin
                                cmd.time_rd = 1'b1;
                                state_next  = ST_CHARGE_WR;
                            end else begin
                                cmd.set_start   = 1'b1;
                                cmd.load_switch = 1'b1;
                            end
                        end
                    end
                    FUNC_VACATE: begin
                        if (sts.core_ok) begin
                            cmd.set_acc = 1'b1;
                            cmd.time_rd = 1'b1;
                            state_next  = ST_VACATE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_CHARGE_WR: begin
                cmd.charge_wr = 1'b1;
                cmd.set_start = 1'b1;
                if (sts.func == FUNC_SWITCH) begin
                    cmd.load_switch = 1'b1;
                    state_next      = ST_FINISH;
                end else begin
                    state_next = ST_POP_RD;
                end
            end
            ST_POP_RD: begin
                if (sts.q_valid) begin
                    cmd.unlink_rd_head = 1'b1;
                    state_next         = ST_POP_WR;
                end else begin
                    cmd.clear_core = 1'b1;
                    state_next     = ST_FINISH;
                end
            end
            ST_POP_WR: begin
                cmd.unlink_wr   = 1'b1;
                cmd.pop_to_core = 1'b1;
                state_next      = ST_FINISH;
            end
            ST_UNLINK_WR: begin
                cmd.unlink_wr = 1'b1;
                state_next    = ST_FINISH;
            end
            ST_VACATE: begin
                cmd.vacate_wr = 1'b1;
                state_next    = ST_FINISH;
            end
            ST_FINISH: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### src/rrq_datapath.sv
// Datapath: queue links, per-core state, run-time tables and the result register
`timescale 1ns / 1ps
`default_nettype none

module rrq_datapath
    import rrq_pkg::*;
#(
    parameter int NUM_THREADS = NUM_THREADS_DEF,
    parameter int NUM_CORES   = NUM_CORES_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [MASK_W-1:0]    cfg_wr_data,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire rrq_cmd_t             cmd,
    output rrq_status_t               sts,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata
);

    localparam int TW = $clog2(NUM_THREADS);
    localparam int CW = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;

    // Configuration and captured item
    logic [MASK_W-1:0]       mask_reg;
    logic [FUNC_W-1:0]       func_reg;
    logic [CORE_FIELD_W-1:0] core_reg;
    logic [TID_W-1:0]        tid_reg;
    logic [TIME_W-1:0]       now_reg;

    // Queue state
    logic [NUM_THREADS-1:0] queued_reg;
    logic                   q_valid_reg;
    logic [TW-1:0]          head_reg;
    logic [TW-1:0]          tail_reg;
    logic [TW-1:0]          ul_tgt_reg;

    // Per-core state
    logic              cur_valid_reg [NUM_CORES];
    logic [TW-1:0]     cur_id_reg    [NUM_CORES];
    logic [TIME_W-1:0] start_reg     [NUM_CORES];

    // Run-time bookkeeping
    logic [NUM_THREADS-1:0] time_valid_reg;
    logic [TIME_W-1:0]      delta_reg;

    // Result under construction and output register
    logic              acc_reg;
    logic              sel_v_reg;
    logic [TID_W-1:0]  sel_t_reg;
    logic              out_v_reg;
    logic [TID_W-1:0]  out_t_reg;
    logic [TIME_W-1:0] out_time_reg;
    logic              m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    // Decoded item
    logic          tid_ok;
    logic          core_ok;
    logic [TW-1:0] tid_idx;
    logic [CW-1:0] core_idx;
    logic          cur_v;
    logic [TW-1:0] cur_id;

    // RAM ports
    logic          nx_we, pv_we, ln_re;
    logic [TW-1:0] nx_waddr, nx_wdata, pv_waddr, pv_wdata, ln_raddr;
    logic [TW-1:0] next_rd, prev_rd;
    logic              tm_we;
    logic [TIME_W-1:0] tm_rdata;

    // Push and unlink decode
    logic          push_en;
    logic [TW-1:0] push_id;
    logic          ul_head, ul_tail;
    logic [TIME_W-1:0] time_rd_val;
    logic [TIME_W-1:0] charge_sum;

    assign tid_ok   = (32'(tid_reg) < 32'(NUM_THREADS));
    assign core_ok  = (32'(core_reg) < 32'(NUM_CORES));
    assign tid_idx  = TW'(tid_reg);
    assign core_idx = CW'(core_reg);
    assign cur_v    = cur_valid_reg[core_idx];
    assign cur_id   = cur_id_reg[core_idx];

    // Status for the controller
    always_comb begin
        sts.func       = func_reg;
        sts.tid_ok     = tid_ok;
        sts.tid_queued = tid_ok && queued_reg[tid_idx];
        sts.core_ok    = core_ok;
        sts.core_en    = mask_reg[core_reg];
        sts.cur_valid  = core_ok && cur_v;
        sts.q_valid    = q_valid_reg;
        sts.out_free   = !m_tvalid_reg || m_tready;
    end

    // Hold the enable mask
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
        end else if (cfg_wr_en) begin
            mask_reg <= cfg_wr_data;
        end
    end

    // Capture the item
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            func_reg <= s_tdata[IN_FUNC_LSB +: FUNC_W];
            core_reg <= s_tdata[IN_CORE_LSB +: CORE_FIELD_W];
            tid_reg  <= s_tdata[IN_TID_LSB +: TID_W];
            now_reg  <= s_tdata[IN_NOW_LSB +: TIME_W];
        end
    end

    // Push source: the item's thread, or the outgoing thread when not yet queued
    assign push_id = cmd.enqueue ? tid_idx : cur_id;
    assign push_en = cmd.enqueue || (cmd.charge_wr && !queued_reg[cur_id]);

    assign ul_head = (head_reg == ul_tgt_reg);
    assign ul_tail = (tail_reg == ul_tgt_reg);

    // Link table writes for push and for unlinking from the middle
    always_comb begin
        nx_we    = 1'b0;
        nx_waddr = tail_reg;
        nx_wdata = push_id;
        pv_we    = 1'b0;
        pv_waddr = push_id;
        pv_wdata = tail_reg;
        if (push_en && q_valid_reg) begin
            nx_we = 1'b1;
            pv_we = 1'b1;
        end else if (cmd.unlink_wr && !ul_head && !ul_tail) begin
            nx_we    = 1'b1;
            nx_waddr = prev_rd;
            nx_wdata = next_rd;
            pv_we    = 1'b1;
            pv_waddr = next_rd;
            pv_wdata = prev_rd;
        end
    end

    assign ln_re    = cmd.unlink_rd_tid || cmd.unlink_rd_head;
    assign ln_raddr = cmd.unlink_rd_tid ? tid_idx : head_reg;

    rrq_ram #(
        .WIDTH (TW),
        .DEPTH (NUM_THREADS)
    ) u_next_ram (
        .aclk  (aclk),
        .we    (nx_we),
        .waddr (nx_waddr),
        .wdata (nx_wdata),
        .re    (ln_re),
        .raddr (ln_raddr),
        .rdata (next_rd)
    );

    rrq_ram #(
        .WIDTH (TW),
        .DEPTH (NUM_THREADS)
    ) u_prev_ram (
        .aclk  (aclk),
        .we    (pv_we),
        .waddr (pv_waddr),
        .wdata (pv_wdata),
        .re    (ln_re),
        .raddr (ln_raddr),
        .rdata (prev_rd)
    );

    // Queue head, tail and membership
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            queued_reg  <= '0;
            q_valid_reg <= 1'b0;
            head_reg    <= '0;
            tail_reg    <= '0;
        end else begin
            if (push_en) begin
                queued_reg[push_id] <= 1'b1;
                tail_reg            <= push_id;
                if (!q_valid_reg) begin
                    head_reg    <= push_id;
                    q_valid_reg <= 1'b1;
                end
            end
            if (cmd.unlink_wr) begin
                queued_reg[ul_tgt_reg] <= 1'b0;
                if (ul_head && ul_tail) begin
                    q_valid_reg <= 1'b0;
                end else if (ul_head) begin
                    head_reg <= next_rd;
                end else if (ul_tail) begin
                    tail_reg <= prev_rd;
                end
            end
        end
    end

    // Remember which thread is being unlinked
    always_ff @(posedge aclk) begin
        if (ln_re) begin
            ul_tgt_reg <= ln_raddr;
        end
    end

    // Run time of the current thread; never-written entries read as zero
    assign time_rd_val = time_valid_reg[cur_id] ? tm_rdata : '0;
    assign charge_sum  = time_rd_val + delta_reg;
    assign tm_we       = cmd.charge_wr;

    rrq_ram #(
        .WIDTH (TIME_W),
        .DEPTH (NUM_THREADS)
    ) u_time_ram (
        .aclk  (aclk),
        .we    (tm_we),
        .waddr (cur_id),
        .wdata (charge_sum),
        .re    (cmd.time_rd),
        .raddr (cur_id),
        .rdata (tm_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_valid_reg <= '0;
        end else if (tm_we) begin
            time_valid_reg[cur_id] <= 1'b1;
        end
    end

    // Elapsed time of the slice ending now
    always_ff @(posedge aclk) begin
        if (cmd.time_rd) begin
            delta_reg <= now_reg - start_reg[core_idx];
        end
    end

    // Per-core current thread and slice start
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < NUM_CORES; c++) begin
                cur_valid_reg[c] <= 1'b0;
            end
        end else begin
            if (cmd.load_switch) begin
                cur_valid_reg[core_idx] <= 1'b1;
            end else if (cmd.pop_to_core) begin
                cur_valid_reg[core_idx] <= 1'b1;
            end else if (cmd.clear_core || cmd.vacate_wr) begin
                cur_valid_reg[core_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_switch) begin
            cur_id_reg[core_idx] <= tid_idx;
        end else if (cmd.pop_to_core) begin
            cur_id_reg[core_idx] <= ul_tgt_reg;
        end else if (cmd.clear_core || cmd.vacate_wr) begin
            cur_id_reg[core_idx] <= '0;
        end
        if (cmd.set_start) begin
            start_reg[core_idx] <= now_reg;
        end
    end

    // Build the result of the item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg   <= 1'b0;
            sel_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end else if (cmd.latch) begin
            acc_reg   <= 1'b0;
            sel_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            if (cmd.set_acc) begin
                acc_reg <= 1'b1;
            end
            if (cmd.load_switch || cmd.pop_to_core) begin
                sel_v_reg <= 1'b1;
            end
            if (cmd.charge_wr || (cmd.vacate_wr && cur_v)) begin
                out_v_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            sel_t_reg    <= '0;
            out_t_reg    <= '0;
            out_time_reg <= '0;
        end else begin
            if (cmd.load_switch) begin
                sel_t_reg <= TID_W'(tid_idx);
            end else if (cmd.pop_to_core) begin
                sel_t_reg <= TID_W'(ul_tgt_reg);
            end
            if (cmd.charge_wr) begin
                out_t_reg    <= TID_W'(cur_id);
                out_time_reg <= charge_sum;
            end else if (cmd.vacate_wr && cur_v) begin
                out_t_reg    <= TID_W'(cur_id);
                out_time_reg <= time_rd_val;
            end
        end
    end

    // Output register: load when free, drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_tdata_reg <= {!q_valid_reg, out_time_reg, out_v_reg, out_t_reg,
                            sel_v_reg, sel_t_reg, acc_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

### src/round_robin_ready_queue.sv
// Round-robin ready queue with per-core dispatch and run-time accounting.
// The time from acceptance until the result can be taken depends on the operation and is
// set by the registered link and run-time reads. One item is handled at a time: the next is
// accepted the cycle after the result is loaded, and a stalled result holds the input off.
// Synchronous reset (aresetn low) empties the queue, frees every core, zeroes run times, mask.
`timescale 1ns / 1ps
`default_nettype none

module round_robin_ready_queue
    import rrq_pkg::*;
#(
    parameter int NUM_THREADS = NUM_THREADS_DEF,
    parameter int NUM_CORES   = NUM_CORES_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [MASK_W-1:0]    cfg_wr_data,   // core_enable_mask
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // func[2:0], core[4:3], thread_id[10:5], now[74:11], zero[79:75]
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // accepted[0], selected_thread[6:1], selected_valid[7], outgoing_thread[13:8],
    // outgoing_valid[14], outgoing_time_used[78:15], queue_empty[79]
    output logic      [M_TDATA_W-1:0] m_tdata
);

    rrq_cmd_t    cmd;
    rrq_status_t sts;

    rrq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rrq_datapath #(
        .NUM_THREADS (NUM_THREADS),
        .NUM_CORES   (NUM_CORES)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .cmd         (cmd),
        .sts         (sts),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

`default_nettype wire

### src/rrq_checker.sv
// Port-level checks of the ready queue, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rrq_checker
    import rrq_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    // A stalled result holds
    `RRQ_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

    // Reset leaves no result pending
    `RRQ_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

    // One item at a time: no new item right after one is taken
    `RRQ_ASSERT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "input ready straight after acceptance")

    // A new result appears only while the input is held off
    `RRQ_ASSERT(a_result_after_work, aclk, aresetn, $rose(m_tvalid) |-> $past(!s_tready), "result appeared while idle")

    // Unused thread fields are zero and a selection implies acceptance
    `RRQ_ASSERT(a_fields_clean, aclk, aresetn, m_tvalid |-> (!m_tdata[OUT_SEL_V_LSB] || m_tdata[OUT_ACC_LSB]) && (m_tdata[OUT_SEL_V_LSB] || m_tdata[OUT_SEL_V_LSB-1:OUT_SEL_T_LSB] == '0) && (m_tdata[OUT_OUT_V_LSB] || m_tdata[OUT_EMPTY_LSB-1:OUT_OUT_T_LSB] == '0), "inconsistent result fields")

endmodule

bind round_robin_ready_queue rrq_checker u_rrq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
